/* src/mexp_pkg.sv */
// shared constants for the modular exponentiation block
`default_nettype none

package mexp_pkg;

    // default field widths
    localparam int unsigned OPERAND_WIDTH_DEF  = 32;
    localparam int unsigned EXPONENT_WIDTH_DEF = 32;

endpackage : mexp_pkg

`default_nettype wire

/* src/mexp_mulmod.sv */
// bit-serial modular multiplier: a * b mod m, one multiplier bit per cycle
`default_nettype none

module mexp_mulmod #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OPERAND_WIDTH-1:0] i_a,
    input  wire logic [OPERAND_WIDTH-1:0] i_b,
    input  wire logic [OPERAND_WIDTH-1:0] i_m,
    output logic                          o_done,
    output logic [OPERAND_WIDTH-1:0]      o_result
);
    import mexp_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_b, n_b;

    // datapath: t = 2*acc + bit*a < 3m, then subtract 0, m or 2m
    logic [W+1:0] t_sum;
    logic [W+2:0] d_one;
    logic [W+2:0] d_two;
    logic [W-1:0] step_acc;

    always_comb begin
        t_sum    = {1'b0, r_acc, 1'b0} + {2'b00, (r_b[W-1] ? i_a : {W{1'b0}})};
        d_one    = {1'b0, t_sum} - {3'b000, i_m};
        d_two    = {1'b0, t_sum} - {2'b00, i_m, 1'b0};
        if (!d_two[W+2]) begin
            step_acc = d_two[W-1:0];
        end else if (!d_one[W+2]) begin
            step_acc = d_one[W-1:0];
        end else begin
            step_acc = t_sum[W-1:0];
        end
    end

    // sequencing of the multiplier bits, msb first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_acc  = '0;
            n_b    = i_b;
        end else if (r_busy) begin
            n_acc = step_acc;
            n_b   = {r_b[W-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_b   <= n_b;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule : mexp_mulmod

`default_nettype wire

/* src/modular_exponentiation.sv */
// modular exponentiation by right-to-left square-and-multiply over one shared multiplier
// the base is first reduced, then each exponent bit up to the top set bit takes a decision
//   step, a multiply when set and a squaring unless no set bit is left, and the result is
//   registered; a zero modulus skips the multiplier and yields zero
// one transaction at a time; the bit-serial multiplier handles one bit per cycle
// reset: synchronous active-low; modulus returns to 1, control idles, output empties
`default_nettype none

module modular_exponentiation #(
    parameter int unsigned OPERAND_WIDTH  = mexp_pkg::OPERAND_WIDTH_DEF,
    parameter int unsigned EXPONENT_WIDTH = mexp_pkg::EXPONENT_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [OPERAND_WIDTH-1:0]  i_cfg_wr_data,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [OPERAND_WIDTH-1:0]  i_base_value,
    input  wire logic [EXPONENT_WIDTH-1:0] i_exponent,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [OPERAND_WIDTH-1:0]       o_power_result
);
    import mexp_pkg::*;

    localparam int unsigned W = OPERAND_WIDTH;
    localparam int unsigned E = EXPONENT_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_FINISH
    } t_state;

    t_state       r_state, n_state;
    logic [W-1:0] r_modulus;
    logic [E-1:0] r_exp, n_exp;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_sq, n_sq;
    logic         r_mm_start, n_mm_start;
    logic [W-1:0] r_mm_a, n_mm_a;
    logic [W-1:0] r_mm_b, n_mm_b;
    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_result, n_result;

    logic         mm_done;
    logic [W-1:0] mm_result;
    logic [W-1:0] one_mod;
    logic         in_txn;

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= W'(1);
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    // 1 mod m
    assign one_mod = W'(r_modulus != W'(1));
    assign in_txn  = i_in_valid && (r_state == S_IDLE);

    // shared modular multiplier
    mexp_mulmod #(
        .OPERAND_WIDTH(W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mm_start),
        .i_a     (r_mm_a),
        .i_b     (r_mm_b),
        .i_m     (r_modulus),
        .o_done  (mm_done),
        .o_result(mm_result)
    );

    // control sequence
    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_mm_start  = 1'b0;
        n_mm_a      = r_mm_a;
        n_mm_b      = r_mm_b;
        n_out_valid = r_out_valid && !i_out_ready;
        n_result    = r_result;
        case (r_state)
            S_IDLE: begin
                if (in_txn) begin
                    n_exp = i_exponent;
                    if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_state = S_FINISH;
                    end else begin
                        // base mod m as (1 mod m) * base
                        n_acc      = one_mod;
                        n_mm_start = 1'b1;
                        n_mm_a     = one_mod;
                        n_mm_b     = i_base_value;
                        n_state    = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mm_done) begin
                    n_sq    = mm_result;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_exp == '0) begin
                    n_state = S_FINISH;
                end else if (r_exp[0]) begin
                    n_mm_start = 1'b1;
                    n_mm_a     = r_acc;
                    n_mm_b     = r_sq;
                    n_state    = S_MUL;
                end else begin
                    n_mm_start = 1'b1;
                    n_mm_a     = r_sq;
                    n_mm_b     = r_sq;
                    n_state    = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    n_acc = mm_result;
                    // no squaring needed once the last set bit is used
                    if ((r_exp >> 1) == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_mm_start = 1'b1;
                        n_mm_a     = r_sq;
                        n_mm_b     = r_sq;
                        n_state    = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    n_sq    = mm_result;
                    n_exp   = r_exp >> 1;
                    n_state = S_STEP;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_result    = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_exp    <= n_exp;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_mm_a   <= n_mm_a;
        r_mm_b   <= n_mm_b;
        r_result <= n_result;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mm_start  <= n_mm_start;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

endmodule : modular_exponentiation

`default_nettype wire

/* src/mexp_checker.sv */
// port-level checker for the modular exponentiation block, bound to the top level
`default_nettype none

module mexp_checker #(
    parameter int unsigned OPERAND_WIDTH  = mexp_pkg::OPERAND_WIDTH_DEF,
    parameter int unsigned EXPONENT_WIDTH = mexp_pkg::EXPONENT_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [OPERAND_WIDTH-1:0]  i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    input  wire logic                      o_in_ready,
    input  wire logic [OPERAND_WIDTH-1:0]  i_base_value,
    input  wire logic [EXPONENT_WIDTH-1:0] i_exponent,
    input  wire logic                      o_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic [OPERAND_WIDTH-1:0]  o_power_result
);
    import mexp_pkg::*;

    localparam int unsigned W = OPERAND_WIDTH;

    logic [W-1:0] r_mod_shadow;

    // shadow copy of the modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_shadow <= W'(1);
        end else if (i_cfg_wr_en) begin
            r_mod_shadow <= i_cfg_wr_data;
        end
    end

    // a waiting input transaction holds its payload
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_base_value) && $stable(i_exponent))
        else $error("input dropped or changed while waiting");

    // a pending result holds until taken
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_power_result))
        else $error("result dropped or changed while stalled");

    // one transaction at a time: ready drops after an input transaction
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // result is always reduced below a nonzero modulus
    a_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_mod_shadow != '0) |-> (o_power_result < r_mod_shadow))
        else $error("result not reduced");

    // zero modulus yields zero
    a_zero_mod : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_mod_shadow == '0) |-> (o_power_result == '0))
        else $error("zero modulus gave nonzero result");

endmodule : mexp_checker

bind modular_exponentiation mexp_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .EXPONENT_WIDTH(EXPONENT_WIDTH)
) u_mexp_checker (.*);

`default_nettype wire
